>>> rtl/core/box_collision_push_out_core_macros.svh
// Assertion macros used by the port-level checker of the push-out core.
// Stands alone; every macro samples on clk and is disabled while rst is high.
`ifndef BOX_COLLISION_PUSH_OUT_CORE_MACROS_SVH
`define BOX_COLLISION_PUSH_OUT_CORE_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define BCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define BCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/bcp_pkg.sv
// Types, constants and helper functions of the box collision push-out core.
// No dependencies; imported by the clamp, push and top modules of the core.
package bcp_pkg;

  // Internal width for offsets, limits and push results.
  localparam int CW = 20;

  localparam int BOX_TABLE_SIZE = 3;

  // Obstacle geometry in tenths of a metre: centre x, centre y, half width, half depth.
  localparam int BOX_TENTHS [BOX_TABLE_SIZE][4] = '{
    '{0, 4, 10, 10},
    '{-28, 22, 7, 5},
    '{28, 22, 7, 5}
  };

  localparam int FLD_CX = 0;
  localparam int FLD_CY = 1;
  localparam int FLD_HW = 2;
  localparam int FLD_HD = 3;

  typedef enum logic [2:0] {
    REG_ROOM_HALF_WIDTH = 3'd0,
    REG_ROOM_HALF_DEPTH = 3'd1,
    REG_WALL_MARGIN     = 3'd2,
    REG_PLAYER_RADIUS   = 3'd3,
    REG_HEIGHT_MIN      = 3'd4,
    REG_HEIGHT_MAX      = 3'd5
  } bcp_reg_t;

  localparam logic [14:0]        RST_ROOM_HALF_WIDTH = 15'd1536;
  localparam logic [14:0]        RST_ROOM_HALF_DEPTH = 15'd1536;
  localparam logic [14:0]        RST_WALL_MARGIN     = 15'd307;
  localparam logic [14:0]        RST_PLAYER_RADIUS   = 15'd218;
  localparam logic signed [15:0] RST_HEIGHT_MIN      = 16'sd0;
  localparam logic signed [15:0] RST_HEIGHT_MAX      = 16'sd307;

  localparam logic signed [CW-1:0] SAT_HI = CW'(32767);
  localparam logic signed [CW-1:0] SAT_LO = CW'(-32768);

  typedef struct packed {
    logic [14:0]        room_half_width;
    logic [14:0]        room_half_depth;
    logic [14:0]        wall_margin;
    logic [14:0]        player_radius;
    logic signed [15:0] height_min;
    logic signed [15:0] height_max;
  } bcp_cfg_t;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } bcp_item_t;

  // Results of the containment test of one box, carried to the push stage.
  typedef struct packed {
    logic                 hit;
    logic                 out_x_side;
    logic                 out_y_side;
    logic                 neg_x;
    logic                 neg_y;
    logic signed [CW-1:0] pen_x;
    logic signed [CW-1:0] pen_y;
  } bcp_probe_t;

  // Converts tenths of a metre to fixed point, rounding half away from zero.
  // Only evaluated at elaboration.
  function automatic int box_fixed(int k, int fld, int frac);
    int t;
    int a;
    int r;
    t = BOX_TENTHS[k][fld];
    a = (t < 0) ? -t : t;
    r = (a * (1 << frac) * 2 + 10) / 20;
    return (t < 0) ? -r : r;
  endfunction

  function automatic logic signed [CW-1:0] sext16(logic signed [15:0] v);
    return {{(CW-16){v[15]}}, v};
  endfunction

  function automatic logic signed [CW-1:0] zext15(logic [14:0] v);
    return $signed({{(CW-15){1'b0}}, v});
  endfunction

  // Clamps v to [-b, b] with b = half - margin; a negative b gives -b below -b, else b.
  function automatic logic signed [15:0] clamp_sym(logic signed [15:0] v, logic [14:0] half,
                                                  logic [14:0] margin);
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] nb;
    logic signed [CW-1:0] vw;
    logic signed [15:0]   r;
    b  = zext15(half) - zext15(margin);
    nb = -b;
    vw = sext16(v);
    if (vw < nb) begin
      r = nb[15:0];
    end else if (vw > b) begin
      r = b[15:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] clamp_range(logic signed [15:0] v,
                                                    logic signed [15:0] lo,
                                                    logic signed [15:0] hi);
    logic signed [15:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [CW-1:0] v);
    logic signed [15:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[15:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[15:0];
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/bcp_clamp.sv
// One pipeline stage that clamps a position to the room and registers it.
// Depends on bcp_pkg.
module bcp_clamp import bcp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  bcp_cfg_t  cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  bcp_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output bcp_item_t out_item
);

  bcp_item_t item_next;

  always_comb begin
    item_next   = in_item;
    item_next.x = clamp_sym(in_item.x, cfg.room_half_width, cfg.wall_margin);
    item_next.y = clamp_sym(in_item.y, cfg.room_half_depth, cfg.wall_margin);
    item_next.z = clamp_range(in_item.z, cfg.height_min, cfg.height_max);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

>>> rtl/core/bcp_push.sv
// Two pipeline stages that resolve a position against one enlarged obstacle box:
// a containment test, then the push to the chosen face. Depends on bcp_pkg.
module bcp_push import bcp_pkg::*; #(
  parameter int BOX       = 0,
  parameter int FRAC_BITS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  bcp_cfg_t  cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  bcp_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output bcp_item_t out_item
);

  localparam logic signed [CW-1:0] CX = CW'(box_fixed(BOX, FLD_CX, FRAC_BITS));
  localparam logic signed [CW-1:0] CY = CW'(box_fixed(BOX, FLD_CY, FRAC_BITS));
  localparam logic signed [CW-1:0] HW = CW'(box_fixed(BOX, FLD_HW, FRAC_BITS));
  localparam logic signed [CW-1:0] HD = CW'(box_fixed(BOX, FLD_HD, FRAC_BITS));

  logic signed [CW-1:0] lim_x;
  logic signed [CW-1:0] lim_y;

  assign lim_x = HW + zext15(cfg.player_radius);
  assign lim_y = HD + zext15(cfg.player_radius);

  // Test stage.
  logic signed [CW-1:0] lx, ly, dx, dy;
  logic signed [CW-1:0] alx, aly, adx, ady;
  bcp_probe_t           probe_next;
  logic                 mid_valid;
  logic                 mid_ready;
  bcp_item_t            mid_item;
  bcp_probe_t           mid_probe;

  always_comb begin
    lx  = sext16(in_item.x) - CX;
    ly  = sext16(in_item.y) - CY;
    dx  = sext16(in_item.px) - CX;
    dy  = sext16(in_item.py) - CY;
    alx = lx[CW-1] ? -lx : lx;
    aly = ly[CW-1] ? -ly : ly;
    adx = dx[CW-1] ? -dx : dx;
    ady = dy[CW-1] ? -dy : dy;
    probe_next.hit        = (alx < lim_x) && (aly < lim_y);
    probe_next.out_x_side = adx >= lim_x;
    probe_next.out_y_side = ady >= lim_y;
    probe_next.neg_x      = lx[CW-1];
    probe_next.neg_y      = ly[CW-1];
    probe_next.pen_x      = lim_x - alx;
    probe_next.pen_y      = lim_y - aly;
  end

  assign in_ready = !mid_valid || mid_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (in_ready) begin
      mid_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mid_item  <= in_item;
      mid_probe <= probe_next;
    end
  end

  // Push stage. Ties in penetration go to y.
  logic                 use_x;
  logic signed [CW-1:0] push_x;
  logic signed [CW-1:0] push_y;
  bcp_item_t            item_next;

  always_comb begin
    if (mid_probe.out_x_side != mid_probe.out_y_side) begin
      use_x = mid_probe.out_x_side;
    end else begin
      use_x = mid_probe.pen_x < mid_probe.pen_y;
    end
    push_x    = CX + (mid_probe.neg_x ? -lim_x : lim_x);
    push_y    = CY + (mid_probe.neg_y ? -lim_y : lim_y);
    item_next = mid_item;
    if (mid_probe.hit) begin
      if (use_x) begin
        item_next.x = sat16(push_x);
      end else begin
        item_next.y = sat16(push_y);
      end
    end
  end

  assign mid_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mid_ready) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_ready && mid_valid) begin
      out_item <= item_next;
    end
  end

endmodule

>>> rtl/core/box_collision_push_out_core.sv
// Box collision push-out core.
// A request on the slave stream carries a previous and a target position in signed
// fixed point; for each one exactly one resolved position leaves on the master stream,
// in the order the requests came in. The target is clamped to the room, pushed out of
// each enlarged obstacle box in turn, and clamped to the room again.
// From acceptance to tvalid a request passes one clamp stage, a test stage and a
// push stage for every box, and a final clamp stage that is also the output register.
// Throughput is one request per cycle while m_tready is high.
// Every stage holds a valid bit and takes new data whenever it is empty or its
// content moves on, so bubbles close up and the input keeps accepting while a
// finished result still waits at the output.
// When the receiver holds m_tready low the stages fill up one by one and s_tready
// falls only once the stage behind the input is full; nothing is dropped or repeated.
// Reset clears every valid bit and loads the configuration registers with defaults;
// the user must write them through the APB port only while the core is idle (unenforced).
module box_collision_push_out_core import bcp_pkg::*; #(
  parameter int NUM_BOXES = 3,
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Slave stream; s_tdata fields from bit 0 up: prev_x, prev_y, target_x, target_y,
  // target_z, 16 bits each.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,
  // Master stream; m_tdata fields from bit 0 up: out_x, out_y, out_z, 16 bits each.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Boxes past the third do not exist, so they get no stages at all.
  localparam int NBOX = (NUM_BOXES < BOX_TABLE_SIZE) ? NUM_BOXES : BOX_TABLE_SIZE;

  // Configuration registers. A write completes in the access cycle of an APB
  // transfer; pready is tied high so every transfer finishes without wait states.
  bcp_cfg_t cfg;
  bcp_reg_t reg_sel;
  logic     cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = bcp_reg_t'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.room_half_width <= RST_ROOM_HALF_WIDTH;
      cfg.room_half_depth <= RST_ROOM_HALF_DEPTH;
      cfg.wall_margin     <= RST_WALL_MARGIN;
      cfg.player_radius   <= RST_PLAYER_RADIUS;
      cfg.height_min      <= RST_HEIGHT_MIN;
      cfg.height_max      <= RST_HEIGHT_MAX;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_ROOM_HALF_WIDTH: cfg.room_half_width <= pwdata[14:0];
        REG_ROOM_HALF_DEPTH: cfg.room_half_depth <= pwdata[14:0];
        REG_WALL_MARGIN:     cfg.wall_margin     <= pwdata[14:0];
        REG_PLAYER_RADIUS:   cfg.player_radius   <= pwdata[14:0];
        REG_HEIGHT_MIN:      cfg.height_min      <= pwdata[15:0];
        REG_HEIGHT_MAX:      cfg.height_max      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Reads return the raw register bits, zero extended; unused addresses read zero.
  always_comb begin
    case (reg_sel)
      REG_ROOM_HALF_WIDTH: prdata = {17'd0, cfg.room_half_width};
      REG_ROOM_HALF_DEPTH: prdata = {17'd0, cfg.room_half_depth};
      REG_WALL_MARGIN:     prdata = {17'd0, cfg.wall_margin};
      REG_PLAYER_RADIUS:   prdata = {17'd0, cfg.player_radius};
      REG_HEIGHT_MIN:      prdata = {16'd0, cfg.height_min};
      REG_HEIGHT_MAX:      prdata = {16'd0, cfg.height_max};
      default:             prdata = 32'd0;
    endcase
  end

  // Pipeline chain. Link 0 is the input stream; link k + 1 is the output of the
  // k-th stage module.
  bcp_item_t chain_item  [NBOX+2];
  logic      chain_valid [NBOX+2];
  logic      chain_ready [NBOX+2];
  bcp_item_t out_item;
  logic      out_valid;

  assign chain_item[0].px = s_tdata[15:0];
  assign chain_item[0].py = s_tdata[31:16];
  assign chain_item[0].x  = s_tdata[47:32];
  assign chain_item[0].y  = s_tdata[63:48];
  assign chain_item[0].z  = s_tdata[79:64];
  assign chain_valid[0]   = s_tvalid;
  assign s_tready         = chain_ready[0];

  bcp_clamp u_clamp_in (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (chain_valid[0]),
    .in_ready  (chain_ready[0]),
    .in_item   (chain_item[0]),
    .out_valid (chain_valid[1]),
    .out_ready (chain_ready[1]),
    .out_item  (chain_item[1])
  );

  for (genvar k = 0; k < NBOX; k++) begin : g_box
    bcp_push #(
      .BOX       (k),
      .FRAC_BITS (FRAC_BITS)
    ) u_push (
      .clk       (clk),
      .rst       (rst),
      .cfg       (cfg),
      .in_valid  (chain_valid[k+1]),
      .in_ready  (chain_ready[k+1]),
      .in_item   (chain_item[k+1]),
      .out_valid (chain_valid[k+2]),
      .out_ready (chain_ready[k+2]),
      .out_item  (chain_item[k+2])
    );
  end

  // The final clamp stage doubles as the output register.
  bcp_clamp u_clamp_out (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (chain_valid[NBOX+1]),
    .in_ready  (chain_ready[NBOX+1]),
    .in_item   (chain_item[NBOX+1]),
    .out_valid (out_valid),
    .out_ready (m_tready),
    .out_item  (out_item)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_item.z, out_item.y, out_item.x};

endmodule

>>> rtl/core/bcp_checker.sv
// Port-level checker for the push-out core, attached to the top level by bind.
// Depends on box_collision_push_out_core_macros.svh.
`include "box_collision_push_out_core_macros.svh"

module bcp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  // A stalled result stays in place unchanged.
  `BCP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // The pipeline comes out of reset empty.
  `BCP_ASSERT_NOW(a_reset_empty, $past(rst), !m_tvalid, "result valid straight after reset")

  // With the output free or moving, every stage can move, so the input must be open.
  `BCP_ASSERT_NOW(a_ready_chain, m_tready || !m_tvalid, s_tready, "input blocked with output free")

endmodule

bind box_collision_push_out_core bcp_checker u_bcp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> verif/bcp_position_checker.sv
// Checker for the box collision push-out core: predicts each resolved position
// from the requests and register writes it sees, and compares the result stream.
// Depends on bcp_pkg for the register codes, reset values and obstacle table.
module bcp_position_checker import bcp_pkg::*; #(
  parameter int NUM_BOXES = 3,
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [79:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatch_count,
  output int          positions_pending
);

  // Shadow copy of the configuration registers.
  int room_x_half;
  int room_y_half;
  int margin;
  int radius;
  int z_floor;
  int z_ceiling;

  // Resolved positions still owed by the core, oldest first, in m_tdata layout.
  logic [47:0] expected_positions [$];

  function automatic int magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  // Obstacle geometry in fixed point, rounded to nearest with ties away from zero.
  function automatic int tenths_q(int k, int fld);
    int t;
    int r;
    t = BOX_TENTHS[k][fld];
    r = (magnitude(t) * (1 << FRAC_BITS) * 2 + 10) / 20;
    return (t < 0) ? -r : r;
  endfunction

  // A negative bound (margin above half size) is handled by testing the low side first.
  function automatic int wall_clamp(int v, int half);
    int b;
    b = half - margin;
    if (v < -b) begin
      return -b;
    end else if (v > b) begin
      return b;
    end
    return v;
  endfunction

  function automatic int height_clamp(int v);
    if (v < z_floor) begin
      return z_floor;
    end else if (v > z_ceiling) begin
      return z_ceiling;
    end
    return v;
  endfunction

  function automatic int sat_q(int v);
    if (v > 32767) begin
      return 32767;
    end else if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  function automatic logic [47:0] resolve_position(logic [79:0] req);
    int px;
    int py;
    int x;
    int y;
    int z;
    int boxes;
    int cx;
    int cy;
    int lim_x;
    int lim_y;
    int lx;
    int ly;
    bit out_x_side;
    bit out_y_side;
    bit along_x;
    px = int'($signed(req[15:0]));
    py = int'($signed(req[31:16]));
    x  = wall_clamp(int'($signed(req[47:32])), room_x_half);
    y  = wall_clamp(int'($signed(req[63:48])), room_y_half);
    z  = height_clamp(int'($signed(req[79:64])));
    boxes = (NUM_BOXES < BOX_TABLE_SIZE) ? NUM_BOXES : BOX_TABLE_SIZE;
    for (int k = 0; k < boxes; k++) begin
      cx    = tenths_q(k, FLD_CX);
      cy    = tenths_q(k, FLD_CY);
      lim_x = tenths_q(k, FLD_HW) + radius;
      lim_y = tenths_q(k, FLD_HD) + radius;
      lx    = x - cx;
      ly    = y - cy;
      // Strictly inside only: an offset equal to the enlarged half size is a touch.
      if (magnitude(lx) < lim_x && magnitude(ly) < lim_y) begin
        out_x_side = magnitude(px - cx) >= lim_x;
        out_y_side = magnitude(py - cy) >= lim_y;
        if (out_x_side != out_y_side) begin
          along_x = out_x_side;
        end else begin
          along_x = (lim_x - magnitude(lx)) < (lim_y - magnitude(ly));
        end
        if (along_x) begin
          x = sat_q(cx + ((lx < 0) ? -lim_x : lim_x));
        end else begin
          y = sat_q(cy + ((ly < 0) ? -lim_y : lim_y));
        end
      end
    end
    x = wall_clamp(x, room_x_half);
    y = wall_clamp(y, room_y_half);
    z = height_clamp(z);
    return {z[15:0], y[15:0], x[15:0]};
  endfunction

  function automatic string field_label(int f);
    case (f)
      0: return "out_x";
      1: return "out_y";
      default: return "out_z";
    endcase
  endfunction

  always @(posedge clk) begin : watch
    logic [47:0] want;
    if (rst) begin
      room_x_half = int'(RST_ROOM_HALF_WIDTH);
      room_y_half = int'(RST_ROOM_HALF_DEPTH);
      margin      = int'(RST_WALL_MARGIN);
      radius      = int'(RST_PLAYER_RADIUS);
      z_floor     = int'(RST_HEIGHT_MIN);
      z_ceiling   = int'(RST_HEIGHT_MAX);
      expected_positions.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (bcp_reg_t'(paddr[4:2]))
          REG_ROOM_HALF_WIDTH: room_x_half = int'(pwdata[14:0]);
          REG_ROOM_HALF_DEPTH: room_y_half = int'(pwdata[14:0]);
          REG_WALL_MARGIN:     margin      = int'(pwdata[14:0]);
          REG_PLAYER_RADIUS:   radius      = int'(pwdata[14:0]);
          REG_HEIGHT_MIN:      z_floor     = int'($signed(pwdata[15:0]));
          REG_HEIGHT_MAX:      z_ceiling   = int'($signed(pwdata[15:0]));
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        expected_positions.push_back(resolve_position(s_tdata));
      end
      if (m_tvalid && m_tready) begin
        if (expected_positions.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
          mismatch_count++;
        end else begin
          want = expected_positions.pop_front();
          for (int f = 0; f < 3; f++) begin
            if (m_tdata[16*f +: 16] !== want[16*f +: 16]) begin
              $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_label(f),
                       $signed(want[16*f +: 16]), $signed(m_tdata[16*f +: 16]));
              mismatch_count++;
            end
          end
        end
      end
    end
    positions_pending = expected_positions.size();
  end

endmodule

>>> verif/tb_box_collision_push_out_core.sv
// Top level of the push-out core testbench: drives requests, the result-side ready
// and register writes, and gives the verdict from the checker's counts.
// Depends on bcp_pkg, bcp_position_checker and the box_collision_push_out_core RTL.
module tb_box_collision_push_out_core import bcp_pkg::*;;

  localparam int OBSTACLES  = 3;
  localparam int FRAC       = 8;
  // Latency from acceptance to tvalid with these parameters; the drain at the end is
  // sized from it and starts once every expected position has arrived.
  localparam int LATENCY    = 2 + 2 * OBSTACLES;
  localparam int RUN_LIMIT  = 2_000_000;
  localparam int IDLE_PCT   = 36;
  // Register indexes past the last one; writes to them must change nothing.
  localparam int REG_SPARE_LO = 6;
  localparam int REG_SPARE_HI = 7;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // Fields from bit 0 up: prev_x, prev_y, target_x, target_y, target_z.
  logic [79:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // Fields from bit 0 up: out_x, out_y, out_z.
  logic [47:0] m_tdata;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [4:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatch_count;
  int positions_pending;

  // When set, neither side idles: a long stretch at full rate.
  bit calm = 1'b0;

  box_collision_push_out_core #(
    .NUM_BOXES(OBSTACLES),
    .FRAC_BITS(FRAC)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bcp_position_checker #(
    .NUM_BOXES(OBSTACLES),
    .FRAC_BITS(FRAC)
  ) position_check (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .mismatch_count   (mismatch_count),
    .positions_pending(positions_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Everything is driven at the falling edge; the core and the checker sample at the
  // rising edge, so nothing depends on the order of events within a time step.
  function automatic bit skip_cycle();
    return !calm && ($urandom_range(99) < IDLE_PCT);
  endfunction

  function automatic logic [79:0] pack_request(int px, int py, int tx, int ty, int tz);
    return {tz[15:0], ty[15:0], tx[15:0], py[15:0], px[15:0]};
  endfunction

  function automatic int near(int centre, int reach);
    return centre + int'($urandom_range(2 * reach)) - reach;
  endfunction

  // Most requests aim at one of the obstacles, so that pushes on either axis, face
  // touches and chains from one box into the next are common. The previous position
  // is close by or well out on one or both axes, so every crossing case turns up.
  // The remaining requests are raw noise over the whole 16-bit range of every field.
  function automatic logic [79:0] draw_request();
    int k;
    int cx;
    int cy;
    int px;
    int py;
    int tz;
    logic [95:0] noise;
    if ($urandom_range(99) < 25) begin
      noise = {$urandom(), $urandom(), $urandom()};
      return noise[79:0];
    end
    k  = $urandom_range(BOX_TABLE_SIZE - 1);
    cx = BOX_TENTHS[k][FLD_CX] * 256 / 10;
    cy = BOX_TENTHS[k][FLD_CY] * 256 / 10;
    case ($urandom_range(3))
      0: begin
        px = near(cx, 300);
        py = near(cy, 300);
      end
      1: begin
        px = near(cx, 1200);
        py = near(cy, 300);
      end
      2: begin
        px = near(cx, 300);
        py = near(cy, 1200);
      end
      default: begin
        px = near(cx, 1200);
        py = near(cy, 1200);
      end
    endcase
    tz = ($urandom_range(1) == 0) ? near(150, 400) : int'($urandom_range(65535));
    return pack_request(px, py, near(cx, 600), near(cy, 600), tz);
  endfunction

  // Offers one request and returns at the falling edge after it was accepted. The
  // valid is left high so that back-to-back requests keep it high across the edge.
  task automatic push_request(input logic [79:0] req);
    while (skip_cycle()) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = req;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // Stops offering and waits until every expected position has come out, which
  // leaves the core idle and ready for register writes.
  task automatic settle();
    s_tvalid = 1'b0;
    while (positions_pending != 0) begin
      @(negedge clk);
    end
  endtask

  // Setup cycle, then access cycle; the write lands at the edge where pready is high.
  task automatic write_register(input int index, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {index[2:0], 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_config(input logic [31:0] half_w, input logic [31:0] half_d,
                            input logic [31:0] margin, input logic [31:0] radius,
                            input logic [31:0] z_lo, input logic [31:0] z_hi);
    settle();
    write_register(REG_ROOM_HALF_WIDTH, half_w);
    write_register(REG_ROOM_HALF_DEPTH, half_d);
    write_register(REG_WALL_MARGIN, margin);
    write_register(REG_PLAYER_RADIUS, radius);
    write_register(REG_HEIGHT_MIN, z_lo);
    write_register(REG_HEIGHT_MAX, z_hi);
  endtask

  task automatic random_phase(input int count, input bit no_idle);
    calm = no_idle;
    for (int i = 0; i < count; i++) begin
      push_request(draw_request());
    end
    calm = 1'b0;
  endtask

  // The receiver stalls at random, except during the calm stretch.
  initial begin
    forever begin
      @(negedge clk);
      m_tready = !skip_cycle();
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed requests under the reset configuration: x and y bounded to +-1229,
    // z to [0, 307]; the central box is enlarged to 474 either way about (0, 102).
    push_request(pack_request(0, 0, 0, 0, 0));
    push_request(pack_request(32767, 32767, 32767, 32767, 32767));
    push_request(pack_request(-32768, -32768, -32768, -32768, -32768));
    push_request(pack_request(32767, -32768, -32768, 32767, 0));
    // Previous position already out on x only, then on y only, then on both.
    push_request(pack_request(-1000, 102, -50, 150, 100));
    push_request(pack_request(0, 900, 30, 300, 100));
    push_request(pack_request(-1000, 900, 400, 112, 100));
    // Zero local offset on the pushed axis goes to the positive face.
    push_request(pack_request(1000, 102, 0, 120, 50));
    push_request(pack_request(0, -900, 100, 102, 50));
    // Touching a face is outside; one step in is inside.
    push_request(pack_request(0, 102, 474, 102, 50));
    push_request(pack_request(0, 102, 0, -372, 50));
    push_request(pack_request(0, 102, 473, 102, 50));
    // Equal penetration on both axes goes to y.
    push_request(pack_request(0, 102, 100, 202, 50));
    // The two side boxes, centred on (-717, 563) and (717, 563).
    push_request(pack_request(-717, 563, -717, 563, 50));
    push_request(pack_request(1300, 563, 800, 600, 50));
    // A push out of the central box along y.
    push_request(pack_request(0, 102, -300, 500, 50));
    // Height below and above the allowed range, and x and y beyond the room.
    push_request(pack_request(0, 0, 1000, 1000, -5000));
    push_request(pack_request(0, 0, -1000, -1000, 5000));
    push_request(pack_request(0, 0, 2000, -2000, 150));

    set_config(1536, 1536, 307, 218, 0, 307);
    random_phase(150, 1'b0);

    set_config(1800, 1400, 200, 300, -100, 400);
    random_phase(120, 1'b1);

    // Every register at its lowest value: the room collapses to a point.
    set_config(0, 0, 0, 0, 32'hFFFF_8000, 32'hFFFF_8000);
    random_phase(60, 1'b0);

    // Widest room and largest radius, so that pushes run past the 16-bit range.
    set_config(32767, 32767, 0, 32767, 32'hFFFF_8000, 32767);
    random_phase(80, 1'b0);

    // Margin above half size gives a negative bound; the height range is inverted.
    set_config(100, 300, 32767, 50, 200, 32'hFFFF_FF38);
    random_phase(60, 1'b0);

    // Writes past the last register must leave the configuration alone.
    set_config(1536, 1536, 307, 218, 0, 307);
    write_register(REG_SPARE_LO, $urandom());
    write_register(REG_SPARE_HI, $urandom());
    random_phase(80, 1'b0);

    // Random register contents, unused upper bits included.
    for (int p = 0; p < 3; p++) begin
      set_config($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      random_phase(50, 1'b0);
    end

    settle();
    repeat (3 * LATENCY) @(negedge clk);
    if (mismatch_count == 0 && positions_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Guards against a core that stops accepting requests or stops producing results.
  initial begin
    #(RUN_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

endmodule
